/* rtl/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the volume table of the tone/noise/envelope
// sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Number of tone voices mixed into one sample.
  localparam int VOICES = 3;

  // Largest single-voice level, and the clamp on the mixed sample.
  localparam int SAMPLE_MAX = 21760;
  localparam int SAMPLE_W   = 15;

  // Width of the raw sum of all voice levels.
  localparam int SUM_W = $clog2(SAMPLE_MAX * VOICES + 1);

  // Divide-by-VOICES through a reciprocal: floor(sum * M / 2^K) is the
  // quotient or one short of it; one compare fixes the short case.
  localparam int DIV_K  = SUM_W;
  localparam int DIV_MW = DIV_K + 1;
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'((2 ** DIV_K) / VOICES);
  localparam int PROD_W = SUM_W + DIV_MW;

  // Register numbers with a fixed role.
  localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
  localparam logic [3:0] REG_MIXER        = 4'd7;
  localparam logic [3:0] REG_ENV_LOW      = 4'd11;
  localparam logic [3:0] REG_ENV_HIGH     = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef struct packed {
    logic cont;
    logic att;
    logic alt;
    logic hold;
  } env_flags_t;

  // Logarithmic volume table.
  function automatic logic [SAMPLE_W-1:0] level_of(input logic [3:0] vol);
    logic [SAMPLE_W-1:0] lv;
    unique case (vol)
      4'd0:  lv = 15'd0;
      4'd1:  lv = 15'd170;
      4'd2:  lv = 15'd240;
      4'd3:  lv = 15'd340;
      4'd4:  lv = 15'd480;
      4'd5:  lv = 15'd680;
      4'd6:  lv = 15'd960;
      4'd7:  lv = 15'd1360;
      4'd8:  lv = 15'd1920;
      4'd9:  lv = 15'd2720;
      4'd10: lv = 15'd3840;
      4'd11: lv = 15'd5440;
      4'd12: lv = 15'd7680;
      4'd13: lv = 15'd10880;
      4'd14: lv = 15'd15360;
      default: lv = 15'd21760;
    endcase
    return lv;
  endfunction

endpackage

/* rtl/psg_tone_noise_envelope.sv */
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// Three-voice sound generator: register file, tone/noise/envelope counters,
// xorshift noise and a logarithmic mixer, one word in and one word out.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload
//   item      item_valid / item_ready      operation, data_value
//   result    result_valid / result_ready  read_data, sample_value, sample_valid
//
// Every input word yields exactly one result word. One word is accepted per
// cycle while the result slot is free or emptying. Each word goes through the
// input register, the state-update stage and the reciprocal divide stage.
// Reset (rst, synchronous) clears the register file and all generator state.
// When the result register holds a word that is not taken, the whole pipe
// holds and item_ready drops; it rises again in the cycle the word is taken.
//
module psg_tone_noise_envelope
  import psg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          operation,
  input  logic [7:0]          data_value,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [7:0]          read_data,
  output logic [SAMPLE_W-1:0] sample_value,
  output logic                sample_valid
);

  // Pipe advance: everything moves when the result slot is free or emptying.
  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // Input register.
  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_data;

  // State-update stage outputs.
  logic             mid_valid;
  logic             mid_tick;
  logic [7:0]       mid_read;
  logic [SUM_W-1:0] mid_sum;

  // Generator state.
  logic [7:0]  regs [16];
  logic [3:0]  sel;
  logic [14:0] tone_counter [VOICES];
  logic [VOICES-1:0] tone_phase;
  logic [7:0]  noise_counter;
  logic [31:0] noise_shift;
  logic        noise_bit;
  logic [18:0] envelope_counter;
  logic [3:0]  envelope_level;
  env_flags_t  env_flags;

  // Next values of a sample tick.
  logic [14:0] tone_counter_next [VOICES];
  logic [VOICES-1:0] tone_phase_next;
  logic [7:0]  noise_counter_next;
  logic [31:0] noise_shift_next;
  logic        noise_bit_next;
  logic [18:0] envelope_counter_next;
  logic [3:0]  envelope_level_next;
  env_flags_t  env_flags_next;
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    logic [4:0]  np;
    logic [7:0]  ncnt;
    logic [31:0] s;
    logic [15:0] ep;
    logic [18:0] ecnt;
    logic        at_end;
    logic [11:0] tp;
    logic [14:0] tcnt;
    logic [15:0] r7;
    logic [7:0]  vr;
    logic        gate;
    logic [3:0]  vol;

    // Noise: a zero period acts as one.
    np = regs[REG_NOISE_PERIOD][4:0];
    if (np == 5'd0) np = 5'd1;
    ncnt = noise_counter + 8'd1;
    s = noise_shift;
    noise_bit_next = noise_bit;
    if (ncnt >= {np, 3'b000}) begin
      ncnt = 8'd0;
      s = s ^ (s >> 7);
      s = s ^ (s << 9);
      s = s ^ (s >> 13);
      noise_bit_next = s[0];
    end
    noise_counter_next = ncnt;
    noise_shift_next   = s;

    // Envelope: step the level, and at the end value apply hold / alternate.
    ep = {regs[REG_ENV_HIGH], regs[REG_ENV_LOW]};
    if (ep == 16'd0) ep = 16'd1;
    ecnt = envelope_counter + 19'd1;
    at_end = 1'b0;
    envelope_level_next = envelope_level;
    env_flags_next      = env_flags;
    if (ecnt >= {ep, 3'b000}) begin
      ecnt = 19'd0;
      if (!env_flags.hold) begin
        at_end = env_flags.att ? (envelope_level == 4'd15) : (envelope_level == 4'd0);
        if (!at_end) begin
          envelope_level_next = env_flags.att ? envelope_level + 4'd1
                                              : envelope_level - 4'd1;
        end else begin
          if (!env_flags.cont) env_flags_next.hold = 1'b1;
          if (env_flags.alt)   env_flags_next.att  = !env_flags.att;
        end
      end
    end
    envelope_counter_next = ecnt;

    // Tone voices and mixer; disable bits past bit 7 read as enabled.
    r7 = {8'd0, regs[REG_MIXER]};
    sum_next = '0;
    for (int c = 0; c < VOICES; c++) begin
      tp = {regs[4'(2 * c + 1)][3:0], regs[4'(2 * c)]};
      if (tp == 12'd0) tp = 12'd1;
      tcnt = tone_counter[c] + 15'd1;
      tone_phase_next[c] = tone_phase[c];
      if (tcnt >= {tp, 3'b000}) begin
        tcnt = 15'd0;
        tone_phase_next[c] = !tone_phase[c];
      end
      tone_counter_next[c] = tcnt;
      vr   = regs[4'(8 + c)];
      gate = (r7[c] || tone_phase_next[c]) && (r7[c + 3] || noise_bit_next);
      vol  = vr[4] ? envelope_level_next : vr[3:0];
      if (gate) sum_next = sum_next + SUM_W'(level_of(vol));
    end
  end

  // Control, state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      mid_valid        <= 1'b0;
      result_valid     <= 1'b0;
      for (int i = 0; i < 16; i++) regs[i] <= 8'd0;
      sel              <= 4'd0;
      for (int c = 0; c < VOICES; c++) tone_counter[c] <= 15'd0;
      tone_phase       <= '0;
      noise_counter    <= 8'd0;
      noise_shift      <= 32'd1;
      noise_bit        <= 1'b0;
      envelope_counter <= 19'd0;
      envelope_level   <= 4'd0;
      env_flags        <= '0;
    end else if (adv) begin
      in_valid     <= item_valid;
      mid_valid    <= in_valid;
      result_valid <= mid_valid;
      if (in_valid) begin
        unique case (in_op)
          OP_SELECT: begin
            sel <= in_data[3:0];
          end
          OP_WRITE: begin
            regs[sel] <= in_data;
            // Shape write restarts the envelope.
            if (sel == REG_ENV_SHAPE) begin
              envelope_counter <= 19'd0;
              env_flags        <= env_flags_t'(in_data[3:0]);
              envelope_level   <= in_data[2] ? 4'd0 : 4'd15;
            end
          end
          OP_READ: begin
          end
          OP_TICK: begin
            tone_counter     <= tone_counter_next;
            tone_phase       <= tone_phase_next;
            noise_counter    <= noise_counter_next;
            noise_shift      <= noise_shift_next;
            noise_bit        <= noise_bit_next;
            envelope_counter <= envelope_counter_next;
            envelope_level   <= envelope_level_next;
            env_flags        <= env_flags_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Divide the raw sum by VOICES.
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quo, rem, quo_fix;

  always_comb begin
    prod    = PROD_W'(mid_sum) * PROD_W'(DIV_M);
    quo     = SUM_W'(prod >> DIV_K);
    rem     = mid_sum - SUM_W'(quo * SUM_W'(VOICES));
    quo_fix = (rem >= SUM_W'(VOICES)) ? quo + SUM_W'(1) : quo;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      in_op    <= op_t'(operation);
      in_data  <= data_value;
      mid_tick <= (in_op == OP_TICK);
      mid_read <= (in_op == OP_READ) ? regs[sel] : 8'd0;
      mid_sum  <= (in_op == OP_TICK) ? sum_next : '0;
      read_data    <= mid_read;
      sample_valid <= mid_tick;
      sample_value <= (quo_fix > SUM_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                                     : SAMPLE_W'(quo_fix);
    end
  end

endmodule
